// ----- rtl/gmvn_pkg.sv -----
package gmvn_pkg;

    localparam int EXW    = 33;
    localparam int DW     = 31;
    localparam int PW     = 62;
    localparam int ACCW   = 64;
    localparam int SUMW   = 66;
    localparam int MAGW   = 63;
    localparam int SIDE_W = 9;
    localparam int LW     = 32;
    localparam int NUMW   = 46;
    localparam int REMW   = 34;
    localparam int QW     = 15;
    localparam int OW     = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [QW-1:0] ONE_Q14 = 15'd16384;

    localparam logic signed [EXW-1:0]  DIFF_LIM = 33'sd1073741823;
    localparam logic signed [SUMW-1:0] ACC_LIM  = 66'sd4611686018427387903;

    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [ACCW-1:0] acc_t;
    typedef logic [MAGW-1:0]        mag_t;
    typedef logic signed [OW-1:0]   nrm_t;

    function automatic diff_t sat_diff(input logic signed [EXW-1:0] d);
        logic signed [EXW-1:0] v;
        v = d;
        if (d > DIFF_LIM)
        begin
            v = DIFF_LIM;
        end
        else if (d < -DIFF_LIM)
        begin
            v = -DIFF_LIM;
        end
        return v[DW-1:0];
    endfunction

    function automatic acc_t sat_acc(input logic signed [SUMW-1:0] s);
        logic signed [SUMW-1:0] v;
        v = s;
        if (s > ACC_LIM)
        begin
            v = ACC_LIM;
        end
        else if (s < -ACC_LIM)
        begin
            v = -ACC_LIM;
        end
        return v[ACCW-1:0];
    endfunction

    // quad offset {row, col} relative to (r-1, c-1)
    function automatic logic [1:0] tri_quad(input logic [2:0] t);
        logic [1:0] q;
        case (t)
            3'd0, 3'd1: q = 2'b00;
            3'd2:       q = 2'b01;
            3'd3:       q = 2'b10;
            3'd4, 3'd5: q = 2'b11;
            default:    q = 2'b00;
        endcase
        return q;
    endfunction

    // vertex offset {dr[1:0], dc[1:0]} relative to (r-1, c-1);
    // even t is triangle (D,A,C), odd t is (A,D,B)
    function automatic logic [3:0] tri_corner(input logic [2:0] t, input logic [1:0] v);
        logic [1:0] q;
        logic [1:0] cr;
        q  = tri_quad(t);
        cr = 2'b00;
        case ({t[0], v})
            3'b000:  cr = 2'b11;
            3'b001:  cr = 2'b00;
            3'b010:  cr = 2'b10;
            3'b100:  cr = 2'b00;
            3'b101:  cr = 2'b11;
            3'b110:  cr = 2'b01;
            default: cr = 2'b00;
        endcase
        return {2'({1'b0, q[1]}) + 2'({1'b0, cr[1]}), 2'({1'b0, q[0]}) + 2'({1'b0, cr[0]})};
    endfunction

endpackage

// ----- rtl/grid_mesh_vertex_normals_core.sv -----
// Grid mesh vertex normals.
// Input channel (in_valid/in_ready): command 0 loads pos_x/y/z into the grid
// entry at vertex_row/vertex_col; command 1 queries the unit normal there.
// Output channel (out_valid/out_ready): one transfer per query carrying
// normal_x/y/z (Q1.14) and status (0 ok, 1 zero-length sum, 2 outside grid).
// cfg_write/cfg_data set grid_side, the side of the grid in use.
// A load produces no output. A query outside the grid goes straight to
// its result with status 2. Other queries step one shared 31x31 multiplier
// through up to six triangles, then a one-bit-per-cycle normalizing shift,
// three squares, a 32-step square root and three 15-step divisions.
// in_ready is high only while idle.
// The result sits in an output register; the next item is accepted while
// it waits, and a finished query holds until that register frees up.
// Reset sets grid_side to 64 and clears control state; grid contents are
// undefined until loaded.
module grid_mesh_vertex_normals_core #(
    parameter int MAX_SIDE   = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [5:0]                   vertex_row,
    input  logic [5:0]                   vertex_col,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           normal_x,
    output logic signed [15:0]           normal_y,
    output logic signed [15:0]           normal_z,
    output logic [1:0]                   status,
    input  logic                         cfg_write,
    input  logic [6:0]                   cfg_data
);
    import gmvn_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int VW    = 3 * CW;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRI   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_RD3   = 4'd4;
    localparam logic [3:0] S_CROSS = 4'd5;
    localparam logic [3:0] S_ABS   = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_DIVI  = 4'd10;
    localparam logic [3:0] S_DIVS  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);
    localparam logic [MAGW-1:0]   M_HI = MAGW'(64'd1 << 30);
    localparam logic [MAGW-1:0]   M_LO = MAGW'(64'd1 << 29);

    function automatic logic signed [EXW-1:0] coord_ext(input logic [VW-1:0] w,
                                                        input int k);
        logic [CW-1:0] c;
        c = w[k*CW +: CW];
        return {{(EXW-CW){c[CW-1]}}, c};
    endfunction

    function automatic logic [AW-1:0] grid_addr(input logic [SIDE_W-1:0] r,
                                                input logic [SIDE_W-1:0] c);
        return AW'(AW'(r) * AW'(MAX_SIDE) + AW'(c));
    endfunction

    // memory
    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // control
    logic [3:0]        state_reg, state_next;
    logic [2:0]        t_reg, t_next;
    logic [4:0]        step_reg, step_next;
    logic [1:0]        k_reg, k_next;
    logic [6:0]        grid_side_reg;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [5:0]        r_reg, r_next;
    logic [5:0]        c_reg, c_next;
    logic [VW-1:0]     p0_reg, p0_next;
    logic [VW-1:0]     p1_reg, p1_next;
    diff_t             u_reg [3];
    diff_t             u_next [3];
    diff_t             w_reg [3];
    diff_t             w_next [3];
    prod_t             pa_reg, pa_next;
    prod_t             pb_reg, pb_next;
    acc_t              acc_reg [3];
    acc_t              acc_next [3];
    mag_t              mag_reg [3];
    mag_t              mag_next [3];
    logic [63:0]       sum_reg, sum_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       bit_reg, bit_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic [REMW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]     quo_reg, quo_next;
    nrm_t              nrm_reg [3];
    nrm_t              nrm_next [3];
    logic [1:0]        res_st_reg, res_st_next;
    nrm_t              nx_reg, ny_reg, nz_reg;
    logic [1:0]        status_reg;
    logic              out_load;

    // shared multiplier
    diff_t             mul_a, mul_b;
    prod_t             mul_p;

    logic [SIDE_W-1:0] side;
    logic              in_fire;
    logic              in_range;
    logic [3:0]        offs;
    logic [1:0]        v_sel;
    logic [SIDE_W-1:0] vr, vc;
    logic [1:0]        quad;
    logic              tri_ok;
    logic [MAGW-1:0]   mmax;
    logic [1:0]        kp1, kp2;
    logic [63:0]       trial;
    logic [REMW-1:0]   rem2;
    logic [QW-1:0]     qv;
    logic [QW-1:0]     qcap;

    assign side     = (SIDE_W'(grid_side_reg) > MAX_SIDE_V) ? MAX_SIDE_V
                                                            : SIDE_W'(grid_side_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_range = (SIDE_W'(vertex_row) < side) && (SIDE_W'(vertex_col) < side);
    assign mem_we   = in_fire && (command == CMD_LOAD) && in_range;
    assign wr_addr  = grid_addr(SIDE_W'(vertex_row), SIDE_W'(vertex_col));

    assign v_sel = (state_reg == S_TRI) ? 2'd0 : ((state_reg == S_RD1) ? 2'd1 : 2'd2);
    assign offs  = tri_corner(t_reg, v_sel);
    assign vr    = SIDE_W'(r_reg) + SIDE_W'(offs[3:2]) - SIDE_W'(1);
    assign vc    = SIDE_W'(c_reg) + SIDE_W'(offs[1:0]) - SIDE_W'(1);
    assign rd_addr = grid_addr(vr, vc);

    assign quad   = tri_quad(t_reg);
    assign tri_ok = (quad[1] ? (SIDE_W'(r_reg) + SIDE_W'(1) < side) : (r_reg != 6'd0)) &&
                    (quad[0] ? (SIDE_W'(c_reg) + SIDE_W'(1) < side) : (c_reg != 6'd0));

    assign kp1 = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
    assign kp2 = (kp1 == 2'd2) ? 2'd0 : kp1 + 2'd1;

    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            mul_a = $signed(mag_reg[k_reg][DW-1:0]);
            mul_b = $signed(mag_reg[k_reg][DW-1:0]);
        end
        else if (step_reg[0])
        begin
            mul_a = u_reg[kp2];
            mul_b = w_reg[kp1];
        end
        else
        begin
            mul_a = u_reg[kp1];
            mul_b = w_reg[kp2];
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax)
        begin
            mmax = mag_reg[1];
        end
        if (mag_reg[2] > mmax)
        begin
            mmax = mag_reg[2];
        end
    end

    assign trial = res_reg + bit_reg;
    assign rem2  = {rem_reg[REMW-2:0], num_reg[QW-1]};
    assign qv    = {quo_reg[QW-2:0], (rem2 >= REMW'(len_reg))};
    assign qcap  = (qv > ONE_Q14) ? ONE_Q14 : qv;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        len_next       = len_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        nrm_next       = nrm_reg;
        res_st_next    = res_st_reg;
        out_load       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (command == CMD_QUERY))
                begin
                    r_next   = vertex_row;
                    c_next   = vertex_col;
                    t_next   = 3'd0;
                    nrm_next = '{default: '0};
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    if (in_range)
                    begin
                        state_next = S_TRI;
                    end
                    else
                    begin
                        res_st_next = ST_OUT;
                        state_next  = S_DONE;
                    end
                end
            end
            S_TRI:
            begin
                if (tri_ok)
                begin
                    state_next = S_RD1;
                end
                else if (t_reg == 3'd5)
                begin
                    state_next = S_ABS;
                end
                else
                begin
                    t_next = t_reg + 3'd1;
                end
            end
            S_RD1:
            begin
                p0_next    = rdata_reg;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                p1_next = rdata_reg;
                for (int i = 0; i < 3; i++)
                begin
                    u_next[i] = sat_diff(coord_ext(p0_reg, i) - coord_ext(rdata_reg, i));
                end
                state_next = S_RD3;
            end
            S_RD3:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_next[i] = sat_diff(coord_ext(p1_reg, i) - coord_ext(rdata_reg, i));
                end
                k_next     = 2'd0;
                step_next  = '0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                if (step_reg == 5'd0)
                begin
                    pa_next   = mul_p;
                    step_next = 5'd1;
                end
                else if (step_reg == 5'd1)
                begin
                    pb_next   = mul_p;
                    step_next = 5'd2;
                end
                else
                begin
                    acc_next[k_reg] = sat_acc({{2{acc_reg[k_reg][ACCW-1]}}, acc_reg[k_reg]}
                                              + {{(SUMW-PW){pa_reg[PW-1]}}, pa_reg}
                                              - {{(SUMW-PW){pb_reg[PW-1]}}, pb_reg});
                    step_next = '0;
                    if (k_reg == 2'd2)
                    begin
                        if (t_reg == 3'd5)
                        begin
                            state_next = S_ABS;
                        end
                        else
                        begin
                            t_next     = t_reg + 3'd1;
                            state_next = S_TRI;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            S_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i] = acc_reg[i][ACCW-1] ? MAGW'(-acc_reg[i]) : MAGW'(acc_reg[i]);
                end
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (mmax == '0)
                begin
                    res_st_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else if (mmax >= M_HI)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (mmax < M_LO)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    k_next     = 2'd0;
                    step_next  = '0;
                    sum_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (step_reg == 5'd0)
                begin
                    pa_next   = mul_p;
                    step_next = 5'd1;
                end
                else
                begin
                    sum_next  = sum_reg + 64'(pa_reg);
                    step_next = '0;
                    if (k_reg == 2'd2)
                    begin
                        res_next   = '0;
                        bit_next   = 64'd1 << 62;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            S_SQRT:
            begin
                if (sum_reg >= trial)
                begin
                    sum_next = sum_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    step_next  = '0;
                    k_next     = 2'd0;
                    len_next   = res_next[LW-1:0];
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                num_next   = NUMW'({mag_reg[k_reg][29:0], 14'd0}) + NUMW'(len_reg >> 1);
                rem_next   = REMW'(num_next >> QW);
                quo_next   = '0;
                step_next  = '0;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                rem_next  = (rem2 >= REMW'(len_reg)) ? rem2 - REMW'(len_reg) : rem2;
                quo_next  = qv;
                num_next  = num_reg << 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(QW - 1))
                begin
                    nrm_next[k_reg] = acc_reg[k_reg][ACCW-1] ? -OW'(qcap) : OW'(qcap);
                    if (k_reg == 2'd2)
                    begin
                        res_st_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_DIVI;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {pos_z, pos_y, pos_x};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            grid_side_reg <= 7'd64;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                grid_side_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        u_reg      <= u_next;
        w_reg      <= w_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        len_reg    <= len_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        nrm_reg    <= nrm_next;
        res_st_reg <= res_st_next;
        if (out_load)
        begin
            nx_reg     <= nrm_reg[0];
            ny_reg     <= nrm_reg[1];
            nz_reg     <= nrm_reg[2];
            status_reg <= res_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign normal_z  = nz_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || status_reg == ST_ZERO ||
                           status_reg == ST_OUT))
        else $error("bad status code");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK |->
            (nx_reg <= 16'sd16384 && nx_reg >= -16'sd16384 &&
             ny_reg <= 16'sd16384 && ny_reg >= -16'sd16384 &&
             nz_reg <= 16'sd16384 && nz_reg >= -16'sd16384))
        else $error("normal component out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |->
            (nx_reg == '0 && ny_reg == '0 && nz_reg == '0))
        else $error("nonzero normal on failed query");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && command == CMD_LOAD && !out_valid_reg |=> !out_valid_reg)
        else $error("load produced a result");
`endif

endmodule
